// ===== src/cpg_island_window_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// CpG island window classifier: assertion macros
// Wraps concurrent assertions so that synthesis sees an empty body.
// ----------------------------------------------------------------------------
`ifndef CPG_ISLAND_WINDOW_CLASSIFIER_MACROS_SVH
`define CPG_ISLAND_WINDOW_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define CPG_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define CPG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define CPG_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define CPG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/cpg_win_pkg.sv =====
// ----------------------------------------------------------------------------
// CpG island window classifier: shared package
// Base classes, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package cpg_win_pkg;

	// Class of one base as held in the window line.
	typedef enum logic [1:0] {
		CLS_OTHER = 2'd0,
		CLS_C     = 2'd1,
		CLS_G     = 2'd2
	} cls_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_WINDOW_LEN = 2'd0,
		REG_MIN_GC     = 2'd1,
		REG_MIN_OE     = 2'd2,
		REG_MIN_CPG    = 2'd3
	} reg_idx_t;

	localparam int BASE_W     = 8;
	localparam int WIN_LEN_W  = 11;
	localparam int MIN_GC_W   = 10;
	localparam int MIN_OE_W   = 20;
	localparam int MIN_CPG_W  = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int POS_W      = 32;
	localparam int CPG_OUT_W  = 10;
	localparam int GC_OUT_W   = 10;
	localparam int OE_OUT_W   = 20;

	localparam logic [WIN_LEN_W-1:0] WIN_LEN_RST = 11'd200;
	localparam logic [MIN_GC_W-1:0]  MIN_GC_RST  = 10'd500;
	localparam logic [MIN_OE_W-1:0]  MIN_OE_RST  = 20'd600;
	localparam logic [MIN_CPG_W-1:0] MIN_CPG_RST = 10'd7;

	localparam int MIN_WINDOW     = 2;
	localparam int DEF_MAX_WINDOW = 1024;

	// Fixed-point scale of both ratios.
	localparam int SCALE   = 1000;
	localparam int SCALE_W = $clog2(SCALE + 1);

	localparam logic [BASE_W-1:0] CHAR_UC_C = 8'h43;
	localparam logic [BASE_W-1:0] CHAR_LC_C = 8'h63;
	localparam logic [BASE_W-1:0] CHAR_UC_G = 8'h47;
	localparam logic [BASE_W-1:0] CHAR_LC_G = 8'h67;

	function automatic cls_t classify(input logic [BASE_W-1:0] ch);
		cls_t cls;
		cls = CLS_OTHER;
		if (ch == CHAR_UC_C || ch == CHAR_LC_C) begin
			cls = CLS_C;
		end else if (ch == CHAR_UC_G || ch == CHAR_LC_G) begin
			cls = CLS_G;
		end
		return cls;
	endfunction

endpackage

`default_nettype wire

// ===== src/cpg_win_line_ram.sv =====
// ----------------------------------------------------------------------------
// CpG window line memory
// Ring of base classes: one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cpg_win_line_ram #(
	parameter int DEPTH = cpg_win_pkg::DEF_MAX_WINDOW,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire cpg_win_pkg::cls_t wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr_a,
	input  wire logic [ADDR_W-1:0] rd_addr_b,
	output cpg_win_pkg::cls_t      rd_data_a,
	output cpg_win_pkg::cls_t      rd_data_b
);

	cpg_win_pkg::cls_t mem_q [DEPTH];
	cpg_win_pkg::cls_t rd_a_q;
	cpg_win_pkg::cls_t rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem_q[rd_addr_a];
			rd_b_q <= mem_q[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

`default_nettype wire

// ===== src/cpg_win_div.sv =====
// ----------------------------------------------------------------------------
// CpG window divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpg_win_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic [NUM_W-1:0]      quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] count_q;
	logic [NUM_W-1:0] work_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             fits;
	logic [DEN_W-1:0] rem_nxt;

	// The work register shifts numerator bits out at the top and takes
	// quotient bits in at the bottom.
	always_comb begin
		shifted = {rem_q, work_q[NUM_W-1]};
		diff    = shifted - {1'b0, den_q};
		fits    = (shifted >= {1'b0, den_q});
		rem_nxt = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (start) begin
			count_q <= CNT_W'(NUM_W);
		end else if (count_q != '0) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (count_q != '0) begin
			work_q <= {work_q[NUM_W-2:0], fits};
			rem_q  <= rem_nxt;
		end
	end

	assign busy = (count_q != '0);
	assign quo  = work_q;

endmodule

`default_nettype wire

// ===== src/cpg_island_window_classifier.sv =====
// ----------------------------------------------------------------------------
// CpG island window classifier
// Sliding window over base classes with C, G and CpG counts, GC content,
// observed/expected ratio and island flag for each base once full.
// ----------------------------------------------------------------------------
//
// Channel  Role    Handshake                    Contents
// item     sink    item_valid / item_stall      base, new_sequence
// result   source  result_valid / result_stall  window_full, is_island,
//                                               window_start, cpg_in_window,
//                                               gc_tenths, oe_milli
// cfg      sink    cfg_valid / cfg_ready        cfg_index, cfg_data
//
// A base that leaves the window not yet full, or a full window without both
// a C and a G, goes from update straight to finish; any other base also passes
// multiply, load and divide, where the bit-serial dividers run. The next base
// is taken in the cycle after the result register loads. Reset clears counts,
// position and control state and resets the configuration; the class memory
// is not cleared. A stalled result holds the block only once the next is ready.
`default_nettype none

`include "cpg_island_window_classifier_macros.svh"

module cpg_island_window_classifier #(
	parameter int MAX_WINDOW = cpg_win_pkg::DEF_MAX_WINDOW
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Item channel
	input  wire logic                               item_valid,
	output logic                                    item_stall,
	input  wire logic [cpg_win_pkg::BASE_W-1:0]     base,
	input  wire logic                               new_sequence,
	// Result channel
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output logic                                    window_full,
	output logic                                    is_island,
	output logic [cpg_win_pkg::POS_W-1:0]           window_start,
	output logic [cpg_win_pkg::CPG_OUT_W-1:0]       cpg_in_window,
	output logic [cpg_win_pkg::GC_OUT_W-1:0]        gc_tenths,
	output logic [cpg_win_pkg::OE_OUT_W-1:0]        oe_milli,
	// Configuration channel
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [cpg_win_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cpg_win_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Widths that follow from the largest window.
	localparam int LEN_W     = $clog2(MAX_WINDOW + 1);
	localparam int ADDR_W    = $clog2(MAX_WINDOW);
	localparam int PAIR_W    = LEN_W - 1;
	localparam int CG_W      = 2 * LEN_W;
	localparam int PL_W      = PAIR_W + LEN_W;
	localparam int GC_NUM_W  = LEN_W + cpg_win_pkg::SCALE_W;
	localparam int OE_NUM_W  = PL_W + cpg_win_pkg::SCALE_W;
	localparam int DIFF_W    = LEN_W + 1;
	localparam int WL_EXT_W  = (LEN_W > cpg_win_pkg::WIN_LEN_W) ? LEN_W :
		cpg_win_pkg::WIN_LEN_W;
	localparam int CPG_CMP_W = (PAIR_W > cpg_win_pkg::CPG_OUT_W) ? PAIR_W :
		cpg_win_pkg::CPG_OUT_W;
	localparam int OE_CMP_W  = (OE_NUM_W > cpg_win_pkg::OE_OUT_W) ? OE_NUM_W :
		cpg_win_pkg::OE_OUT_W;
	localparam int POS_W     = cpg_win_pkg::POS_W;
	localparam int CPG_MAX   = (1 << cpg_win_pkg::CPG_OUT_W) - 1;
	localparam int GC_MAX    = (1 << cpg_win_pkg::GC_OUT_W) - 1;
	localparam int OE_MAX    = (1 << cpg_win_pkg::OE_OUT_W) - 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MULT,
		ST_LOAD,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   result_valid_q;

	// Configuration registers.
	logic [cpg_win_pkg::WIN_LEN_W-1:0] window_len_q;
	logic [cpg_win_pkg::MIN_GC_W-1:0]  min_gc_q;
	logic [cpg_win_pkg::MIN_OE_W-1:0]  min_oe_q;
	logic [cpg_win_pkg::MIN_CPG_W-1:0] min_cpg_q;

	// Window state.
	logic [LEN_W-1:0]  c_q;
	logic [LEN_W-1:0]  g_q;
	logic [PAIR_W-1:0] pair_q;
	logic [LEN_W-1:0]  fill_q;
	logic [POS_W-1:0]  pos_q;
	cpg_win_pkg::cls_t prev_q;
	logic [ADDR_W-1:0] head_q;

	// Per-item pipeline registers.
	cpg_win_pkg::cls_t cls_s1;
	logic              full_s2;
	logic              zero_s2;
	logic [POS_W-1:0]  start_s2;
	logic [CG_W-1:0]   cg_s3;
	logic [PL_W-1:0]   pl_s3;
	logic [LEN_W-1:0]  sum_s3;

	// Result register payload.
	logic                                full_q;
	logic                                island_q;
	logic [POS_W-1:0]                    start_q;
	logic [cpg_win_pkg::CPG_OUT_W-1:0]   cpg_q;
	logic [cpg_win_pkg::GC_OUT_W-1:0]    gc_q;
	logic [cpg_win_pkg::OE_OUT_W-1:0]    oe_q;

	logic item_acc;
	logic cfg_acc;
	logic out_load;

	// ------------------------------------------------------------------
	// Handshakes. An item is taken only in idle; the core is busy from the
	// transfer until its result sits in the result register.
	// ------------------------------------------------------------------
	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign cfg_ready  = (state_q == ST_IDLE);
	assign cfg_acc    = cfg_valid && cfg_ready;
	assign out_load   = (state_q == ST_FINISH) && (!result_valid_q || !result_stall);

	// ------------------------------------------------------------------
	// Effective window length: clamped to the range the memory supports.
	// ------------------------------------------------------------------
	logic [WL_EXT_W-1:0] wl_ext;
	logic [LEN_W-1:0]    len_eff;

	always_comb begin
		wl_ext = WL_EXT_W'(window_len_q);
		if (wl_ext < WL_EXT_W'(cpg_win_pkg::MIN_WINDOW)) begin
			len_eff = LEN_W'(cpg_win_pkg::MIN_WINDOW);
		end else if (wl_ext > WL_EXT_W'(MAX_WINDOW)) begin
			len_eff = LEN_W'(MAX_WINDOW);
		end else begin
			len_eff = LEN_W'(wl_ext);
		end
	end

	// ------------------------------------------------------------------
	// Memory addresses. The oldest base sits len places behind the write
	// pointer, and the base after it one place further on, both modulo the
	// ring size. Both are read at the transfer, the new class is written in
	// the update cycle, so the read always sees the entry before it is
	// overwritten, even when the window spans the whole ring.
	// ------------------------------------------------------------------
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_WINDOW - 1);

	logic [DIFF_W-1:0] diff_raw;
	logic [DIFF_W-1:0] diff_wrap;
	logic [ADDR_W-1:0] rd_addr_old;
	logic [ADDR_W-1:0] rd_addr_next;
	logic [ADDR_W-1:0] head_nxt;
	cpg_win_pkg::cls_t rd_oldest;
	cpg_win_pkg::cls_t rd_next;

	always_comb begin
		diff_raw  = DIFF_W'(head_q) - DIFF_W'(len_eff);
		diff_wrap = diff_raw[DIFF_W-1] ? (diff_raw + DIFF_W'(MAX_WINDOW)) : diff_raw;
		rd_addr_old  = diff_wrap[ADDR_W-1:0];
		rd_addr_next = (rd_addr_old == LAST_ADDR) ? '0 : (rd_addr_old + ADDR_W'(1));
		head_nxt     = (head_q == LAST_ADDR) ? '0 : (head_q + ADDR_W'(1));
	end

	cpg_win_line_ram #(
		.DEPTH (MAX_WINDOW)
	) u_line_ram (
		.clk       (clk),
		.wr_en     (state_q == ST_UPDATE),
		.wr_addr   (head_q),
		.wr_data   (cls_s1),
		.rd_en     (item_acc),
		.rd_addr_a (rd_addr_old),
		.rd_addr_b (rd_addr_next),
		.rd_data_a (rd_oldest),
		.rd_data_b (rd_next)
	);

	// ------------------------------------------------------------------
	// Update cycle: retire the oldest base when the window is full, then
	// count the new one. A CpG pair leaves with its C and enters with its G.
	// ------------------------------------------------------------------
	logic              full_before;
	logic [LEN_W-1:0]  c_dec;
	logic [LEN_W-1:0]  g_dec;
	logic [PAIR_W-1:0] pair_dec;
	logic [LEN_W-1:0]  c_nxt;
	logic [LEN_W-1:0]  g_nxt;
	logic [PAIR_W-1:0] pair_nxt;
	logic [LEN_W-1:0]  fill_nxt;
	logic [POS_W-1:0]  pos_nxt;
	logic              full_after;
	logic              zero_nxt;

	always_comb begin
		full_before = (fill_q >= len_eff);
		c_dec       = c_q;
		g_dec       = g_q;
		pair_dec    = pair_q;
		if (full_before) begin
			if (rd_oldest == cpg_win_pkg::CLS_C && rd_next == cpg_win_pkg::CLS_G &&
					pair_q != '0) begin
				pair_dec = pair_q - PAIR_W'(1);
			end
			if (rd_oldest == cpg_win_pkg::CLS_C && c_q != '0) begin
				c_dec = c_q - LEN_W'(1);
			end else if (rd_oldest == cpg_win_pkg::CLS_G && g_q != '0) begin
				g_dec = g_q - LEN_W'(1);
			end
		end

		c_nxt    = c_dec;
		g_nxt    = g_dec;
		pair_nxt = pair_dec;
		if (cls_s1 == cpg_win_pkg::CLS_C) begin
			c_nxt = c_dec + LEN_W'(1);
		end else if (cls_s1 == cpg_win_pkg::CLS_G) begin
			g_nxt = g_dec + LEN_W'(1);
		end
		if (prev_q == cpg_win_pkg::CLS_C && cls_s1 == cpg_win_pkg::CLS_G) begin
			pair_nxt = pair_dec + PAIR_W'(1);
		end

		fill_nxt   = full_before ? fill_q : (fill_q + LEN_W'(1));
		pos_nxt    = pos_q + POS_W'(1);
		full_after = (fill_nxt >= len_eff);
		zero_nxt   = (c_nxt == '0) || (g_nxt == '0);
	end

	// ------------------------------------------------------------------
	// Dividers. GC content is (c + g) * 1000 / len and the observed over
	// expected ratio is pairs * len * 1000 / (c * g); both run side by side.
	// ------------------------------------------------------------------
	logic                div_start;
	logic [GC_NUM_W-1:0] gc_num;
	logic [OE_NUM_W-1:0] oe_num;
	logic                gc_busy;
	logic                oe_busy;
	logic [GC_NUM_W-1:0] gc_quo;
	logic [OE_NUM_W-1:0] oe_quo;

	assign div_start = (state_q == ST_LOAD);
	assign gc_num    = GC_NUM_W'(sum_s3) * GC_NUM_W'(cpg_win_pkg::SCALE);
	assign oe_num    = OE_NUM_W'(pl_s3) * OE_NUM_W'(cpg_win_pkg::SCALE);

	cpg_win_div #(
		.NUM_W (GC_NUM_W),
		.DEN_W (LEN_W)
	) u_gc_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (gc_num),
		.den    (len_eff),
		.busy   (gc_busy),
		.quo    (gc_quo)
	);

	cpg_win_div #(
		.NUM_W (OE_NUM_W),
		.DEN_W (CG_W)
	) u_oe_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (oe_num),
		.den    (cg_s3),
		.busy   (oe_busy),
		.quo    (oe_quo)
	);

	// ------------------------------------------------------------------
	// Result: saturate to the field widths and compare with the thresholds.
	// When C or G is absent both ratios read as zero; a window that is not
	// yet full yields an all-zero result.
	// ------------------------------------------------------------------
	logic [CPG_CMP_W-1:0]              pair_ext;
	logic [OE_CMP_W-1:0]               oe_ext;
	logic [cpg_win_pkg::CPG_OUT_W-1:0] cpg_val;
	logic [cpg_win_pkg::GC_OUT_W-1:0]  gc_val;
	logic [cpg_win_pkg::OE_OUT_W-1:0]  oe_val;
	logic                              island_val;
	logic [POS_W-1:0]                  start_val;

	always_comb begin
		pair_ext = CPG_CMP_W'(pair_q);
		oe_ext   = OE_CMP_W'(oe_quo);
		cpg_val  = (pair_ext > CPG_CMP_W'(CPG_MAX)) ?
			cpg_win_pkg::CPG_OUT_W'(CPG_MAX) : cpg_win_pkg::CPG_OUT_W'(pair_ext);
		gc_val   = (gc_quo > GC_NUM_W'(GC_MAX)) ?
			cpg_win_pkg::GC_OUT_W'(GC_MAX) : gc_quo[cpg_win_pkg::GC_OUT_W-1:0];
		oe_val   = (oe_ext > OE_CMP_W'(OE_MAX)) ?
			cpg_win_pkg::OE_OUT_W'(OE_MAX) : cpg_win_pkg::OE_OUT_W'(oe_ext);
		if (zero_s2) begin
			gc_val = '0;
			oe_val = '0;
		end
		start_val  = start_s2;
		island_val = (cpg_val >= min_cpg_q) && (gc_val >= min_gc_q) &&
			(oe_val >= min_oe_q);
		if (!full_s2) begin
			cpg_val    = '0;
			gc_val     = '0;
			oe_val     = '0;
			start_val  = '0;
			island_val = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer and result valid.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (full_after && !zero_nxt) begin
						state_q <= ST_MULT;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_MULT: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (!gc_busy && !oe_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= cpg_win_pkg::WIN_LEN_RST;
			min_gc_q     <= cpg_win_pkg::MIN_GC_RST;
			min_oe_q     <= cpg_win_pkg::MIN_OE_RST;
			min_cpg_q    <= cpg_win_pkg::MIN_CPG_RST;
		end else if (cfg_acc) begin
			case (cfg_index)
				cpg_win_pkg::REG_WINDOW_LEN: begin
					window_len_q <= cfg_data[cpg_win_pkg::WIN_LEN_W-1:0];
				end
				cpg_win_pkg::REG_MIN_GC: begin
					min_gc_q <= cfg_data[cpg_win_pkg::MIN_GC_W-1:0];
				end
				cpg_win_pkg::REG_MIN_OE: begin
					min_oe_q <= cfg_data[cpg_win_pkg::MIN_OE_W-1:0];
				end
				cpg_win_pkg::REG_MIN_CPG: begin
					min_cpg_q <= cfg_data[cpg_win_pkg::MIN_CPG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Window counts, position and ring pointer. A new sequence clears them
	// at the transfer, so the update cycle already starts from an empty
	// window; a write to the window length register clears them as well.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q    <= '0;
			g_q    <= '0;
			pair_q <= '0;
			fill_q <= '0;
			pos_q  <= '0;
			prev_q <= cpg_win_pkg::CLS_OTHER;
			head_q <= '0;
		end else begin
			if (state_q == ST_UPDATE) begin
				c_q    <= c_nxt;
				g_q    <= g_nxt;
				pair_q <= pair_nxt;
				fill_q <= fill_nxt;
				pos_q  <= pos_nxt;
				prev_q <= cls_s1;
				head_q <= head_nxt;
			end else if ((item_acc && new_sequence) ||
					(cfg_acc && cfg_index == cpg_win_pkg::REG_WINDOW_LEN)) begin
				c_q    <= '0;
				g_q    <= '0;
				pair_q <= '0;
				fill_q <= '0;
				pos_q  <= '0;
				prev_q <= cpg_win_pkg::CLS_OTHER;
				head_q <= '0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Pipeline and result payload registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (item_acc) begin
			cls_s1 <= cpg_win_pkg::classify(base);
		end
		if (state_q == ST_UPDATE) begin
			full_s2  <= full_after;
			zero_s2  <= zero_nxt;
			start_s2 <= pos_nxt - POS_W'(len_eff) + POS_W'(1);
		end
		if (state_q == ST_MULT) begin
			cg_s3  <= CG_W'(c_q) * CG_W'(g_q);
			pl_s3  <= PL_W'(pair_q) * PL_W'(len_eff);
			sum_s3 <= LEN_W'(c_q + g_q);
		end
		if (out_load) begin
			full_q   <= full_s2;
			island_q <= island_val;
			start_q  <= start_val;
			cpg_q    <= cpg_val;
			gc_q     <= gc_val;
			oe_q     <= oe_val;
		end
	end

	assign result_valid  = result_valid_q;
	assign window_full   = full_q;
	assign is_island     = island_q;
	assign window_start  = start_q;
	assign cpg_in_window = cpg_q;
	assign gc_tenths     = gc_q;
	assign oe_milli      = oe_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`CPG_ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= len_eff, "fill count beyond window length")
	`CPG_ASSERT_ALWAYS(a_count_bound, clk, arst_n, (DIFF_W'(c_q) + DIFF_W'(g_q)) <= DIFF_W'(fill_q), "C and G counts exceed fill count")
	`CPG_ASSERT_ALWAYS(a_pair_bound, clk, arst_n, LEN_W'(pair_q) <= c_q, "CpG count exceeds C count")
	`CPG_ASSERT_IMPLY(a_empty_result, clk, arst_n, result_valid && !window_full, !is_island && window_start == '0 && cpg_in_window == '0 && gc_tenths == '0 && oe_milli == '0, "result of a partial window is not all zero")

endmodule

`default_nettype wire
